>>> rtl/pwco_pkg.sv
// Package for the position-weighted complex overlap block.
// Holds the fixed-point widths, the item and command structs and the register codes.
// No dependencies.
package pwco_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COORD_WIDTH  = 16;
  localparam int ACC_WIDTH    = 64;
  localparam int VOL_WIDTH    = 16;
  localparam int COMP_WIDTH   = 32;
  localparam int MAG_WIDTH    = 64;
  localparam int NUM_SUMS     = 6;
  localparam int NUM_PRODS    = 8;
  localparam int IDX_WIDTH    = 3;

  localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
  localparam int OVL_WIDTH    = PROD_WIDTH + 2;
  localparam int TERM_WIDTH   = OVL_WIDTH + COORD_WIDTH;
  localparam int OUT_SHIFT    = 2 * (SAMPLE_WIDTH - 1);
  localparam int HI_WIDTH     = ACC_WIDTH - OUT_SHIFT;
  localparam int HI_PROD_W    = HI_WIDTH + VOL_WIDTH + 1;
  localparam int LO_PROD_W    = OUT_SHIFT + VOL_WIDTH;

  localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NUM_SUMS - 1);

  // Configuration register indexes, decoded from the word address.
  localparam logic REG_SPINOR_MODE = 1'b0;
  localparam logic REG_VOLUME      = 1'b1;

  localparam logic                 MODE_RESET   = 1'b1;
  localparam logic [VOL_WIDTH-1:0] VOLUME_RESET = 16'd4096;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] a_up_re;
    logic signed [SAMPLE_WIDTH-1:0] a_up_im;
    logic signed [SAMPLE_WIDTH-1:0] a_dn_re;
    logic signed [SAMPLE_WIDTH-1:0] a_dn_im;
    logic signed [SAMPLE_WIDTH-1:0] h_up_re;
    logic signed [SAMPLE_WIDTH-1:0] h_up_im;
    logic signed [SAMPLE_WIDTH-1:0] h_dn_re;
    logic signed [SAMPLE_WIDTH-1:0] h_dn_im;
    logic signed [COORD_WIDTH-1:0]  x_pos;
    logic signed [COORD_WIDTH-1:0]  y_pos;
    logic signed [COORD_WIDTH-1:0]  z_pos;
    logic                           last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] dip_x_re;
    logic signed [COMP_WIDTH-1:0] dip_x_im;
    logic signed [COMP_WIDTH-1:0] dip_y_re;
    logic signed [COMP_WIDTH-1:0] dip_y_im;
    logic signed [COMP_WIDTH-1:0] dip_z_re;
    logic signed [COMP_WIDTH-1:0] dip_z_im;
    logic [MAG_WIDTH-1:0]         dip_mag_sq;
    logic                         sat_flag;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;
    logic                 sum;
    logic                 term;
    logic                 acc;
    logic                 o_mul;
    logic                 o_rnd;
    logic                 o_sq;
    logic                 o_mag;
    logic                 emit;
    logic [IDX_WIDTH-1:0] idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/pwco_ctrl.sv
// Controller state machine for the position-weighted overlap block.
// Sequences the per-point steps and the six-component output pass.
// Depends on pwco_pkg.
module pwco_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pwco_pkg::dp_stat_t stat,
  output pwco_pkg::dp_cmd_t  cmd
);
  import pwco_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_TERM = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_OMUL = 4'd4;
  localparam logic [3:0] S_ORND = 4'd5;
  localparam logic [3:0] S_OSQ  = 4'd6;
  localparam logic [3:0] S_OMAG = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [IDX_WIDTH-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.term  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        cnt_nxt = '0;
        if (stat.last) begin
          state_nxt = S_OMUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OMUL: begin
        cmd.o_mul = 1'b1;
        state_nxt = S_ORND;
      end
      S_ORND: begin
        cmd.o_rnd = 1'b1;
        state_nxt = S_OSQ;
      end
      S_OSQ: begin
        cmd.o_sq  = 1'b1;
        state_nxt = S_OMAG;
      end
      S_OMAG: begin
        cmd.o_mag = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_OMUL;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_accept_reaches_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##3 (state_r == S_ACC))
    else $error("accepted item did not reach the accumulate step");

  a_emit_after_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r == LAST_IDX))
    else $error("result emitted before all six components were formed");

endmodule

>>> rtl/pwco_dp.sv
// Datapath for the position-weighted overlap block: products, weighting,
// saturating accumulators, output scaling, magnitude sum and output register.
// Depends on pwco_pkg.
module pwco_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pwco_pkg::in_item_t        in_data,
  input  logic                      mode,
  input  logic [pwco_pkg::VOL_WIDTH-1:0] vol,
  input  pwco_pkg::dp_cmd_t         cmd,
  output pwco_pkg::dp_stat_t        stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output pwco_pkg::out_item_t       out_data
);
  import pwco_pkg::*;

  localparam logic [LO_PROD_W:0] RND_HALF = (LO_PROD_W+1)'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [COMP_WIDTH-1:0] COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [COMP_WIDTH-1:0] COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  logic signed [PROD_WIDTH-1:0]  p_r [NUM_PRODS];
  logic signed [COORD_WIDTH-1:0] pos_r [3];
  logic                          last_r;
  logic signed [OVL_WIDTH-1:0]   t_re_r, t_im_r;
  logic signed [TERM_WIDTH-1:0]  term_r [NUM_SUMS];
  logic signed [ACC_WIDTH-1:0]   sums_r [NUM_SUMS];
  logic                          sat_seen_r;

  logic signed [HI_PROD_W-1:0]   hi_prod_r;
  logic [LO_PROD_W-1:0]          lo_prod_r;
  logic signed [COMP_WIDTH-1:0]  comp_r [NUM_SUMS];
  logic signed [COMP_WIDTH-1:0]  cur_r;
  logic [MAG_WIDTH-1:0]          sq_r;
  logic [MAG_WIDTH-1:0]          mag_r;
  logic                          osat_r;

  logic                          out_valid_r;
  out_item_t                     out_r;

  // Saturating accumulate of every lane.
  logic signed [ACC_WIDTH-1:0]   acc_nxt [NUM_SUMS];
  logic                          acc_sat [NUM_SUMS];
  logic                          acc_any_sat;

  always_comb begin
    logic signed [ACC_WIDTH:0] s;
    acc_any_sat = 1'b0;
    for (int j = 0; j < NUM_SUMS; j++) begin
      s = (ACC_WIDTH+1)'(sums_r[j]) + (ACC_WIDTH+1)'(term_r[j]);
      acc_sat[j] = (s[ACC_WIDTH] != s[ACC_WIDTH-1]);
      if (acc_sat[j]) begin
        acc_nxt[j] = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_nxt[j] = s[ACC_WIDTH-1:0];
      end
      acc_any_sat = acc_any_sat | acc_sat[j];
    end
  end

  // Output scaling: the sum is split where the output drops its low bits, so the
  // multiply by the volume element stays narrow; the low part carries the rounding.
  logic signed [ACC_WIDTH-1:0]   sel_sum;
  logic [LO_PROD_W:0]            lo_rnd;
  logic signed [HI_PROD_W:0]     r_full;
  logic                          r_sat;
  logic signed [COMP_WIDTH-1:0]  r_comp;
  logic [COMP_WIDTH-1:0]         cur_abs;
  logic [MAG_WIDTH:0]            mag_sum;

  always_comb begin
    sel_sum = sums_r[cmd.idx];
    lo_rnd  = {1'b0, lo_prod_r} + RND_HALF;
    r_full  = (HI_PROD_W+1)'(hi_prod_r)
            + $signed({1'b0, (HI_PROD_W)'(lo_rnd[LO_PROD_W:OUT_SHIFT])});
    r_sat   = (r_full[HI_PROD_W:COMP_WIDTH-1] != {(HI_PROD_W-COMP_WIDTH+2){1'b0}}) &&
              (r_full[HI_PROD_W:COMP_WIDTH-1] != {(HI_PROD_W-COMP_WIDTH+2){1'b1}});
    if (r_sat) begin
      r_comp = r_full[HI_PROD_W] ? COMP_MIN : COMP_MAX;
    end else begin
      r_comp = r_full[COMP_WIDTH-1:0];
    end
    cur_abs = cur_r[COMP_WIDTH-1] ? (~cur_r + 1'b1) : cur_r;
    mag_sum = {1'b0, mag_r} + {1'b0, sq_r};
  end

  // Per-point pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r[0]   <= in_data.a_up_re * in_data.h_up_re;
      p_r[1]   <= in_data.a_up_im * in_data.h_up_im;
      p_r[2]   <= in_data.a_dn_re * in_data.h_dn_re;
      p_r[3]   <= in_data.a_dn_im * in_data.h_dn_im;
      p_r[4]   <= in_data.a_up_im * in_data.h_up_re;
      p_r[5]   <= in_data.a_dn_im * in_data.h_dn_re;
      p_r[6]   <= in_data.a_up_re * in_data.h_up_im;
      p_r[7]   <= in_data.a_dn_re * in_data.h_dn_im;
      pos_r[0] <= in_data.x_pos;
      pos_r[1] <= in_data.y_pos;
      pos_r[2] <= in_data.z_pos;
      last_r   <= in_data.last_point;
    end
    if (cmd.sum) begin
      if (mode) begin
        t_re_r <= OVL_WIDTH'(p_r[0]) + OVL_WIDTH'(p_r[1])
                + OVL_WIDTH'(p_r[2]) + OVL_WIDTH'(p_r[3]);
        t_im_r <= OVL_WIDTH'(p_r[4]) + OVL_WIDTH'(p_r[5])
                - OVL_WIDTH'(p_r[6]) - OVL_WIDTH'(p_r[7]);
      end else begin
        // Real mode: up-spin real parts only, imaginary lanes get zero.
        t_re_r <= OVL_WIDTH'(p_r[0]);
        t_im_r <= '0;
      end
    end
    if (cmd.term) begin
      for (int k = 0; k < 3; k++) begin
        term_r[2*k]   <= t_re_r * pos_r[k];
        term_r[2*k+1] <= t_im_r * pos_r[k];
      end
    end
    if (cmd.o_mul) begin
      hi_prod_r <= $signed(sel_sum[ACC_WIDTH-1:OUT_SHIFT]) * $signed({1'b0, vol});
      lo_prod_r <= sel_sum[OUT_SHIFT-1:0] * vol;
    end
    if (cmd.o_rnd) begin
      comp_r[cmd.idx] <= r_comp;
      cur_r           <= r_comp;
    end
    if (cmd.o_sq) begin
      sq_r <= cur_abs * cur_abs;
    end
    if (cmd.emit) begin
      out_r.dip_x_re   <= comp_r[0];
      out_r.dip_x_im   <= comp_r[1];
      out_r.dip_y_re   <= comp_r[2];
      out_r.dip_y_im   <= comp_r[3];
      out_r.dip_z_re   <= comp_r[4];
      out_r.dip_z_im   <= comp_r[5];
      out_r.dip_mag_sq <= mag_r;
      out_r.sat_flag   <= sat_seen_r | osat_r;
    end
  end

  // Accumulators and the running output flags; cleared by reset and on emit.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      for (int j = 0; j < NUM_SUMS; j++) begin
        sums_r[j] <= '0;
      end
      sat_seen_r <= 1'b0;
      mag_r      <= '0;
      osat_r     <= 1'b0;
    end else begin
      if (cmd.acc) begin
        for (int j = 0; j < NUM_SUMS; j++) begin
          sums_r[j] <= acc_nxt[j];
        end
        sat_seen_r <= sat_seen_r | acc_any_sat;
      end
      if (cmd.o_rnd && r_sat) begin
        osat_r <= 1'b1;
      end
      if (cmd.o_mag) begin
        if (mag_sum[MAG_WIDTH]) begin
          mag_r  <= '1;
          osat_r <= 1'b1;
        end else begin
          mag_r <= mag_sum[MAG_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.last     = last_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result appeared without an emit command");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (sums_r[0] == '0 && sums_r[5] == '0 && !sat_seen_r && mag_r == '0))
    else $error("accumulators not cleared after a result");

endmodule

>>> rtl/position_weighted_complex_overlap.sv
// Position-weighted complex overlap (transition dipole) accumulator, top level.
// Holds the configuration registers and joins the controller and the datapath.
// Depends on pwco_pkg, pwco_ctrl and pwco_dp.
//
// Usage: each input item is one grid point of a state pair: electron and hole
// samples (Q1.15) and the point's coordinates (Q7.8). The item is taken at a
// clock edge with in_valid high and in_stall low. At acceptance eight 16x16
// products are registered; the overlap sum, the six coordinate weightings and
// the six saturating 64-bit adds follow one per cycle; in_stall stays high
// until the adds are done, so no new item is taken while one is in flight.
// A point marked last_point then starts an output pass: the six sums pass one
// at a time through a scale step (volume multiply, round, saturate to Q12.20),
// a square and a magnitude add, and the result register is loaded once the
// result port is free. The result appears on out_valid/out_data and stays
// there, unchanged, while out_stall is high. Input items keep flowing while a
// result waits; a following result is held back, and the input with it, until
// the waiting one has been taken. Once a result is loaded the accumulators and
// the saturation history are cleared. Reset (rst_n low, synchronous) clears
// all sums, drops out_valid and loads spinor_mode = 1 and volume_element =
// 4096 (1.0). The registers sit at byte address 0 and 4 of the APB-style port
// and should only be written while idle.
module position_weighted_complex_overlap (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input item channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pwco_pkg::in_item_t   in_data,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output pwco_pkg::out_item_t  out_data,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import pwco_pkg::*;

  logic                 mode_r;
  logic [VOL_WIDTH-1:0] vol_r;
  logic                 cfg_wr;
  logic                 reg_sel;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The register index is the word address; byte lanes are ignored.
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      vol_r  <= VOLUME_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SPINOR_MODE: mode_r <= pwdata[0];
        REG_VOLUME:      vol_r  <= pwdata[VOL_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SPINOR_MODE: prdata = {31'b0, mode_r};
      REG_VOLUME:      prdata = {{(32-VOL_WIDTH){1'b0}}, vol_r};
      default:         prdata = '0;
    endcase
  end

  // The controller steps one point at a time through the datapath and runs
  // the output pass when the datapath reports a last point.
  pwco_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pwco_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .mode      (mode_r),
    .vol       (vol_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> test/pwco_dipole_checker.sv
// Scoreboard for the position-weighted complex overlap block: watches the item,
// result and register ports, predicts every dipole result and compares it.
// Depends on pwco_pkg for the item structs and the register indexes.
module pwco_dipole_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pwco_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pwco_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  dipoles_pending,
  output int                  points_seen,
  output int                  results_seen,
  output int                  flagged_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import pwco_pkg::*;

  // Products of two Q1.15 samples carry 30 fraction bits.
  localparam int     FRAC_BITS = 30;
  localparam longint ACC_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam longint COMP_MAX  = 64'sd2147483647;
  localparam longint COMP_MIN  = -COMP_MAX - 1;

  // Shadow of the block state: sums in order x_re, x_im, y_re, y_im, z_re, z_im.
  longint      moments [6];
  logic        overflowed;
  logic        spinor;
  logic [15:0] volume;
  out_item_t   dipoles_due [$];

  function automatic longint widen(logic [15:0] v);
    longint r;
    r = $signed(v);
    return r;
  endfunction

  function automatic longint widen32(logic [31:0] v);
    longint r;
    r = $signed(v);
    return r;
  endfunction

  function automatic void add_moment(int k, longint term);
    if (term > 0 && moments[k] > ACC_MAX - term) begin
      moments[k] = ACC_MAX;
      overflowed = 1'b1;
    end else if (term < 0 && moments[k] < ACC_MIN - term) begin
      moments[k] = ACC_MIN;
      overflowed = 1'b1;
    end else begin
      moments[k] += term;
    end
  endfunction

  // Multiply by the volume, drop the fraction bits with round-half-up, clamp to 32 bits.
  function automatic logic [31:0] scale_moment(longint s, inout logic clipped);
    longint whole;
    longint frac;
    longint vol;
    longint r;
    vol   = volume;
    whole = s >>> FRAC_BITS;
    frac  = s & ((64'sd1 <<< FRAC_BITS) - 1);
    r = whole * vol + ((frac * vol + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    if (r > COMP_MAX) begin
      clipped = 1'b1;
      r = COMP_MAX;
    end else if (r < COMP_MIN) begin
      clipped = 1'b1;
      r = COMP_MIN;
    end
    return r[31:0];
  endfunction

  function automatic void accumulate_point(in_item_t p);
    longint              aur, aui, adr, adi, hur, hui, hdr, hdi;
    longint              pos [3];
    longint              t_re, t_im, c;
    longint unsigned     m, sq, mag;
    logic                clipped;
    logic [31:0]         comps [6];
    out_item_t           dip;
    aur = widen(p.a_up_re);  aui = widen(p.a_up_im);
    adr = widen(p.a_dn_re);  adi = widen(p.a_dn_im);
    hur = widen(p.h_up_re);  hui = widen(p.h_up_im);
    hdr = widen(p.h_dn_re);  hdi = widen(p.h_dn_im);
    pos[0] = widen(p.x_pos);
    pos[1] = widen(p.y_pos);
    pos[2] = widen(p.z_pos);
    if (spinor) begin
      t_re = aur * hur + aui * hui + adr * hdr + adi * hdi;
      t_im = aui * hur + adi * hdr - aur * hui - adr * hdi;
    end else begin
      t_re = aur * hur;
      t_im = 0;
    end
    for (int k = 0; k < 3; k++) begin
      add_moment(2 * k, t_re * pos[k]);
      if (spinor) add_moment(2 * k + 1, t_im * pos[k]);
    end
    points_seen++;
    if (!p.last_point) return;

    clipped = overflowed;
    mag = 0;
    for (int k = 0; k < 6; k++) begin
      comps[k] = scale_moment(moments[k], clipped);
      c  = widen32(comps[k]);
      m  = (c < 0) ? -c : c;
      sq = m * m;
      if (mag > ~64'd0 - sq) begin
        mag = ~64'd0;
        clipped = 1'b1;
      end else begin
        mag += sq;
      end
    end
    dip.dip_x_re   = comps[0];
    dip.dip_x_im   = comps[1];
    dip.dip_y_re   = comps[2];
    dip.dip_y_im   = comps[3];
    dip.dip_z_re   = comps[4];
    dip.dip_z_im   = comps[5];
    dip.dip_mag_sq = mag;
    dip.sat_flag   = clipped;
    dipoles_due.push_back(dip);
    moments    = '{default: 0};
    overflowed = 1'b0;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
    end
  endfunction

  function automatic void check_dipole(out_item_t got);
    out_item_t want;
    if (dipoles_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("dipole result with none outstanding: %h", got);
      return;
    end
    want = dipoles_due.pop_front();
    results_seen++;
    if (want.sat_flag) flagged_results++;
    compare_field("dip_x_re", 64'(want.dip_x_re), 64'(got.dip_x_re));
    compare_field("dip_x_im", 64'(want.dip_x_im), 64'(got.dip_x_im));
    compare_field("dip_y_re", 64'(want.dip_y_re), 64'(got.dip_y_re));
    compare_field("dip_y_im", 64'(want.dip_y_im), 64'(got.dip_y_im));
    compare_field("dip_z_re", 64'(want.dip_z_re), 64'(got.dip_z_re));
    compare_field("dip_z_im", 64'(want.dip_z_im), 64'(got.dip_z_im));
    compare_field("dip_mag_sq", want.dip_mag_sq, got.dip_mag_sq);
    compare_field("sat_flag", 64'(want.sat_flag), 64'(got.sat_flag));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      moments    = '{default: 0};
      overflowed = 1'b0;
      spinor     = MODE_RESET;
      volume     = VOLUME_RESET;
      dipoles_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SPINOR_MODE) spinor = pwdata[0];
        else if (paddr[2] == REG_VOLUME) volume = pwdata[15:0];
      end
      // Results are checked before the new point is predicted: a result can
      // never belong to the point accepted at the same edge.
      if (out_valid && !out_stall) check_dipole(out_data);
      if (in_valid && !in_stall) accumulate_point(in_data);
    end
    dipoles_pending = dipoles_due.size();
  end

endmodule

>>> test/position_weighted_complex_overlap_tb.sv
// Top of the testbench for position_weighted_complex_overlap: drives grid
// points, register writes and result back-pressure, and reports the verdict.
// Depends on pwco_pkg, the block itself and pwco_dipole_checker.
module position_weighted_complex_overlap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwco_pkg::*;

  localparam int HALF_PERIOD  = 2;
  // Points without a result leave no trace on the result side, so settling
  // waits DRAIN_CYCLES for the block to finish them.
  localparam int DRAIN_CYCLES = 48;
  localparam int LONG_HOLD    = 400;
  localparam int TOTAL_POINTS = 470;
  // This allows many times the slowest legal run.
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus controls read by the result sink. quiet removes all idling on
  // both sides; pressure_phase starts one long hold-off on the result side.
  logic        quiet = 1'b0;
  logic        pressure_phase = 1'b0;

  int          points_sent = 0;
  int          cfg_writes = 0;

  int          mismatches;
  int          dipoles_pending;
  int          points_seen;
  int          results_seen;
  int          flagged_results;

  always #HALF_PERIOD clk = ~clk;

  position_weighted_complex_overlap i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pwco_dipole_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .dipoles_pending (dipoles_pending),
    .points_seen     (points_seen),
    .results_seen    (results_seen),
    .flagged_results (flagged_results)
  );

  // Samples favor the corners of the Q1.15 and Q7.8 ranges and small values,
  // where sign handling and rounding are most likely to go wrong; the rest
  // are uniform so that every bit toggles.
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 63)) - 16'd32;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_point(logic last);
    in_item_t p;
    p.a_up_re    = rand_sample();
    p.a_up_im    = rand_sample();
    p.a_dn_re    = rand_sample();
    p.a_dn_im    = rand_sample();
    p.h_up_re    = rand_sample();
    p.h_up_im    = rand_sample();
    p.h_dn_re    = rand_sample();
    p.h_dn_im    = rand_sample();
    p.x_pos      = rand_sample();
    p.y_pos      = rand_sample();
    p.z_pos      = rand_sample();
    p.last_point = last;
    return p;
  endfunction

  function automatic in_item_t make_point(logic [15:0] aur, aui, adr, adi,
                                          logic [15:0] hur, hui, hdr, hdi,
                                          logic [15:0] x, y, z, logic last);
    in_item_t p;
    p.a_up_re = aur;  p.a_up_im = aui;  p.a_dn_re = adr;  p.a_dn_im = adi;
    p.h_up_re = hur;  p.h_up_im = hui;  p.h_dn_re = hdr;  p.h_dn_im = hdi;
    p.x_pos = x;  p.y_pos = y;  p.z_pos = z;
    p.last_point = last;
    return p;
  endfunction

  // Offers one grid point. Entered and left at a falling edge. While the
  // sender idles, the payload carries noise with valid low; once valid is
  // raised the payload holds until the item is taken.
  task automatic send_point(input in_item_t p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_valid <= 1'b0;
      in_data  <= rand_point(1'($urandom_range(0, 1)));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    points_sent++;
    @(negedge clk);
  endtask

  // One state pair: n points, the final one marked last.
  task automatic send_pair(input int n);
    for (int i = 0; i < n; i++) send_point(rand_point(i == n - 1));
  endtask

  // Lowers valid and waits until every predicted result has been taken, then
  // lets the block finish any point that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (dipoles_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  // Result sink. Each result waits out a random stall_left once it shows up;
  // the pressure phase adds one long hold-off counted here, during which the
  // sender keeps offering points so that the block backs up into its input.
  initial begin : result_sink
    int   stall_left;
    int   hold_left;
    logic taken;
    logic hold_seen;
    stall_left = $urandom_range(0, 9);
    hold_left  = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk);
      taken = out_valid && !out_stall;
      @(negedge clk);
      if (taken) stall_left = quiet ? 0 : $urandom_range(0, 9);
      if (pressure_phase && !hold_seen) hold_left = LONG_HOLD;
      hold_seen = pressure_phase;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (out_valid && stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int          phase;
    int          phase_end;
    int          n;
    logic        mode;
    logic [15:0] vol;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset settings (complex mode, unit volume).
    // Full-scale positive and negative corners of every field.
    send_point(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
    send_point(make_point(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 1'b1));
    // Opposite signs between electron and hole give a large negative real part.
    send_point(make_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                          16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                          16'h8000, 16'h7FFF, 16'h0000, 1'b1));
    send_point(make_point('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    send_pair(3);
    // Rounding ties: x lands exactly on +0.5 LSB, y exactly on -0.5 LSB;
    // both round toward plus infinity.
    send_point(make_point(16'd2, '0, '0, '0, 16'd4, '0, '0, '0,
                          16'h4000, 16'hC000, 16'h0000, 1'b1));

    // Real single-spin mode: the imaginary sums must stay at zero even with
    // large imaginary samples. Upper data bits are junk and must be ignored.
    settle();
    write_reg(REG_SPINOR_MODE, 32'hFFFF_FFFE);
    send_point(make_point(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                          16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                          16'h1234, 16'h8000, 16'h7FFF, 1'b0));
    send_pair(1);

    // Mode switched in the middle of a pair: the sums gathered in real mode
    // survive, the later points are complex.
    send_point(rand_point(1'b0));
    send_point(rand_point(1'b0));
    settle();
    write_reg(REG_SPINOR_MODE, 32'hFFFF_FFFF);
    send_point(rand_point(1'b0));
    send_point(rand_point(1'b1));

    // Zero volume: every component and the magnitude come out as zero.
    settle();
    write_reg(REG_VOLUME, 32'hABCD_0000);
    send_point(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000,
                          16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));

    // Largest volume: all six components clip, once toward the top and once
    // toward the bottom of the range, and the magnitude clips both times.
    settle();
    write_reg(REG_VOLUME, 32'hFFFF_FFFF);
    send_point(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000,
                          16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
    send_point(make_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000,
                          16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_pair(2);
    settle();
    write_reg(REG_VOLUME, 32'h0000_1000);

    // Random part, in phases with their own register settings. The first
    // three phases pin down useful corners: plain settings, real mode, and
    // the pressure phase with a long result hold-off and short pairs. Every
    // fifth phase runs without any idling on either side.
    phase = 0;
    while (points_sent < TOTAL_POINTS) begin
      settle();
      case (phase)
        0: begin mode = 1'b1; vol = 16'd4096; end
        1: begin mode = 1'b0; vol = 16'($urandom()); end
        2: begin mode = 1'b1; vol = 16'd4096; end
        default: begin
          mode = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 3))
            0: vol = 16'h0000;
            1: vol = 16'hFFFF;
            2: vol = 16'd4096;
            default: vol = 16'($urandom_range(0, 8192));
          endcase
        end
      endcase
      write_reg(REG_SPINOR_MODE, {31'($urandom()), mode});
      write_reg(REG_VOLUME, {16'($urandom()), vol});
      quiet          <= (phase % 5 == 4);
      pressure_phase <= (phase == 2);
      phase_end = points_sent + 60;
      while (points_sent < phase_end && points_sent < TOTAL_POINTS) begin
        if (phase == 2) n = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0) n = $urandom_range(6, 12);
        else n = $urandom_range(1, 4);
        send_pair(n);
      end
      phase++;
    end

    settle();
    $display("Ran %0d grid points in %0d phases with %0d register writes;",
             points_seen, phase, cfg_writes);
    $display("checked %0d dipole results, %0d of them with the saturation flag set.",
             results_seen, flagged_results);
    if (mismatches == 0 && dipoles_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("Timed out with %0d dipole results still outstanding.", dipoles_pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
